// File: rtl/float32_square_root_defines.svh
// Assertion macros for the square root RTL.
`ifndef FLOAT32_SQUARE_ROOT_DEFINES_SVH
`define FLOAT32_SQUARE_ROOT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FSQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define FSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/fsqrt_pkg.sv
// Package with the types and constants of the square root block.
package fsqrt_pkg;
  localparam int unsigned RootSteps = 25;
  localparam logic [31:0] CanonNan  = 32'h7fc0_0000;
  localparam logic [31:0] QuietBit  = 32'h0040_0000;
  localparam logic [31:0] HalfBias  = 32'h3f00_0000;

  typedef enum logic [2:0] {
    StIdle,
    StNorm,
    StRoot,
    StPack,
    StDone
  } fsqrt_state_e;

  // Control handed from the sequencer to the recurrence unit.
  typedef struct packed {
    logic load;
    logic step;
  } fsqrt_ctrl_t;
endpackage

// File: rtl/fsqrt_recur.sv
// Restoring bit-by-bit square root recurrence, one result bit per cycle while step is asserted.
module fsqrt_recur
  import fsqrt_pkg::*;
(
  input  logic        clk_i,
  input  fsqrt_ctrl_t ctrl_i,
  input  logic [26:0] mant_i,
  output logic [24:0] quot_o,
  output logic        sticky_o
);
  logic [26:0] rem_q, rem_d;
  logic [26:0] s_q, s_d;
  logic [24:0] q_q, q_d;
  logic [24:0] r_q, r_d;
  logic [26:0] t;

  // Load, or one recurrence step: trial subtract and shift.
  always_comb begin
    t     = s_q + {2'b00, r_q};
    rem_d = rem_q;
    s_d   = s_q;
    q_d   = q_q;
    r_d   = r_q;
    if (ctrl_i.load) begin
      rem_d = mant_i;
      s_d   = '0;
      q_d   = '0;
      r_d   = 25'h100_0000;
    end else if (ctrl_i.step) begin
      if (t <= rem_q) begin
        s_d   = t + {2'b00, r_q};
        rem_d = rem_q - t;
        q_d   = q_q | r_q;
      end
      rem_d = {rem_d[25:0], 1'b0};
      r_d   = {1'b0, r_q[24:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    s_q   <= s_d;
    q_q   <= q_d;
    r_q   <= r_d;
  end

  assign quot_o   = q_q;
  assign sticky_o = |rem_q;
endmodule

// File: rtl/float32_square_root.sv
// Top level of the binary32 square root with its sequencer.
// An accepted operand passes the normalise, recurrence, pack and done states; special cases go straight to done.
// Normalising a subnormal shifts one bit per cycle until the leading one reaches the top bit.
// The recurrence retires one root bit per cycle, 25 root bits in all.
// Throughput: one transaction at a time; a new one is taken once the result is taken.
// Reset clears the sequencer and the output valid flag asynchronously.
`include "float32_square_root_defines.svh"
module float32_square_root
  import fsqrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        operand_bits_valid_i,
  output logic        operand_bits_ready_o,
  input  logic [31:0] operand_bits_i,
  output logic        root_bits_valid_o,
  input  logic        root_bits_ready_i,
  output logic [31:0] root_bits_o
);
  fsqrt_state_e state_q, state_d;
  logic [23:0]  mant_q, mant_d;
  logic [9:0]   eb_q, eb_d;
  logic [4:0]   cnt_q, cnt_d;
  logic [31:0]  res_q, res_d;
  logic         vld_q, vld_d;
  fsqrt_ctrl_t  ctrl;
  logic [24:0]  quot;
  logic         sticky;
  logic [26:0]  rmant;
  logic [24:0]  qr;
  logic [7:0]   expf;
  logic [22:0]  frac;
  logic [9:0]   half;

  assign expf  = operand_bits_i[30:23];
  assign frac  = operand_bits_i[22:0];
  // Operand doubled once, twice when the biased exponent is odd.
  assign rmant = eb_q[0] ? {1'b0, mant_q, 2'b00} : {2'b00, mant_q, 1'b0};

  fsqrt_recur u_recur (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .mant_i  (rmant),
    .quot_o  (quot),
    .sticky_o(sticky)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q <= mant_d;
    eb_q   <= eb_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  // Sequencer: decode, normalise, recur, round and pack.
  always_comb begin
    state_d = state_q;
    mant_d  = mant_q;
    eb_d    = eb_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    vld_d   = vld_q;
    ctrl    = '0;
    qr      = '0;
    half    = '0;
    operand_bits_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        operand_bits_ready_o = 1'b1;
        if (operand_bits_valid_i) begin
          mant_d = {1'b0, frac};
          // A subnormal starts from an exponent field of one.
          eb_d   = 10'd130;
          if (expf == 8'hff) begin
            if (frac != '0) res_d = operand_bits_i | QuietBit;
            else res_d = operand_bits_i[31] ? CanonNan : operand_bits_i;
            state_d = StDone;
          end else if (operand_bits_i[30:0] == '0) begin
            res_d   = operand_bits_i;
            state_d = StDone;
          end else if (operand_bits_i[31]) begin
            res_d   = CanonNan;
            state_d = StDone;
          end else if (expf == '0) begin
            state_d = StNorm;
          end else begin
            mant_d  = {1'b1, frac};
            eb_d    = {2'b00, expf} + 10'd129;
            state_d = StNorm;
          end
        end
      end
      StNorm: begin
        if (mant_q[23]) begin
          ctrl.load = 1'b1;
          cnt_d     = 5'(RootSteps - 1);
          state_d   = StRoot;
        end else begin
          mant_d = {mant_q[22:0], 1'b0};
          eb_d   = eb_q - 10'd1;
        end
      end
      StRoot: begin
        ctrl.step = 1'b1;
        cnt_d     = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = StPack;
      end
      StPack: begin
        qr      = quot + {24'd0, sticky & quot[0]};
        half    = {1'b0, eb_q[9:1]} - 10'd128;
        res_d   = {8'd0, qr[24:1]} + HalfBias + {half[8:0], 23'd0};
        state_d = StDone;
      end
      StDone: begin
        vld_d = 1'b1;
        if (vld_q && root_bits_ready_i) begin
          vld_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign root_bits_valid_o = vld_q;
  assign root_bits_o       = res_q;

  `FSQ_ASSERT_IMP(a_valid_only_done, clk_i, rst_ni, vld_q, state_q == StDone)
  `FSQ_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, operand_bits_ready_o, !vld_q)
  `FSQ_ASSERT_NEXT(a_root_to_pack, clk_i, rst_ni, state_q == StRoot && cnt_q == '0, state_q == StPack)
endmodule

// File: tb/tb_float32_square_root.sv
// Testbench for the binary32 square root: random and directed operands checked against a predictor.
`timescale 1ns / 100ps
module tb_float32_square_root;
  import fsqrt_pkg::*;

  localparam int unsigned NumRandom = 1200;
  localparam int unsigned IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        operand_bits_valid_i;
  logic        operand_bits_ready_o;
  logic [31:0] operand_bits_i;
  logic        root_bits_valid_o;
  logic        root_bits_ready_i;
  logic [31:0] root_bits_o;

  logic [31:0] pending_operands[$];
  logic [31:0] expected_roots[$];
  int unsigned num_errors;
  int unsigned num_checked;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_off;
  bit          stimulus_done;

  float32_square_root i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .operand_bits_valid_i(operand_bits_valid_i),
    .operand_bits_ready_o(operand_bits_ready_o),
    .operand_bits_i      (operand_bits_i),
    .root_bits_valid_o   (root_bits_valid_o),
    .root_bits_ready_i   (root_bits_ready_i),
    .root_bits_o         (root_bits_o)
  );

  // Square root of a binary32 pattern, rounded to nearest even.
  function automatic logic [31:0] predict_root(logic [31:0] x);
    logic [7:0]  exp_field;
    logic [31:0] mant;
    logic [31:0] quot;
    logic [31:0] partial;
    logic [31:0] bit_pos;
    logic [31:0] trial;
    int          biased;
    int          half_exp;
    exp_field = x[30:23];
    if (exp_field == 8'hff) begin
      if (x[22:0] != 0) return x | QuietBit;
      return x[31] ? CanonNan : x;
    end
    if (x[30:0] == 0) return x;
    if (x[31]) return CanonNan;
    mant = {8'd0, x[23:0]};
    if (exp_field == 0) begin
      biased = 1;
      while (mant[23] == 1'b0) begin
        mant = mant << 1;
        biased--;
      end
    end else begin
      biased = exp_field;
    end
    biased = biased - 127 + 256;
    mant = {8'd0, 1'b1, mant[22:0]};
    if (biased[0]) mant = mant << 1;
    half_exp = (biased >>> 1) - 128;
    mant = mant << 1;
    quot = 0;
    partial = 0;
    bit_pos = 32'h0100_0000;
    while (bit_pos != 0) begin
      trial = partial + bit_pos;
      if (trial <= mant) begin
        partial = trial + bit_pos;
        mant = mant - trial;
        quot = quot + bit_pos;
      end
      mant = mant << 1;
      bit_pos = bit_pos >> 1;
    end
    if (mant != 0) quot = quot + (quot & 1);
    return (quot >> 1) + HalfBias + (32'(half_exp) << 23);
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
    num_errors++;
  endtask

  // Draws a gap: mostly zero or short, now and then long.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random operand spread over the interesting classes.
  function automatic logic [31:0] random_operand();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return {raw[31], 8'd0, raw[22:0] >> $urandom_range(0, 22)};
      1: return {raw[31], 8'hff, raw[22:0]};
      2: return {raw[31], 31'd0};
      3: return {1'b0, raw[30:0]} & ~(32'h1 << $urandom_range(0, 22));
      4: return {1'b1, raw[30:0]};
      default: return {1'b0, raw[30:0]};
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Fill the queue: special cases and extremes, then random operands.
  initial begin
    pending_operands = '{
      32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
      32'h7fc0_0000, 32'h7f80_0001, 32'hffbf_ffff, 32'h7fff_ffff,
      32'h0000_0001, 32'h007f_ffff, 32'h0040_0000, 32'h8000_0001,
      32'hbf80_0000, 32'h0080_0000, 32'h7f7f_ffff, 32'h3f80_0000,
      32'h4080_0000, 32'h4000_0000, 32'h4040_0000, 32'h3f80_0001,
      32'h3fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0002
    };
    for (int i = 0; i < NumRandom; i++) pending_operands.push_back(random_operand());
  end

  // Driver: offers queued operands with random gaps between transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operand_bits_valid_i <= 1'b0;
      operand_bits_i <= '0;
      send_gap <= 0;
      stimulus_done <= 1'b0;
    end else if (operand_bits_valid_i && !operand_bits_ready_o) begin
      // Hold the offered transaction.
    end else begin
      if (operand_bits_valid_i) expected_roots.push_back(predict_root(operand_bits_i));
      if (send_gap != 0 || pending_operands.size() == 0) begin
        operand_bits_valid_i <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
        if (pending_operands.size() == 0) stimulus_done <= 1'b1;
      end else begin
        operand_bits_valid_i <= 1'b1;
        operand_bits_i <= pending_operands.pop_front();
        send_gap <= draw_gap();
      end
    end
  end

  // Monitor: random ready with one long hold-off early on; checks each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_bits_ready_i <= 1'b0;
      recv_gap <= 0;
      hold_off <= 300;
      num_checked <= 0;
    end else begin
      if (root_bits_valid_o && root_bits_ready_i) begin
        num_checked <= num_checked + 1;
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result", root_bits_o, 32'h0);
        end else begin
          logic [31:0] want;
          want = expected_roots.pop_front();
          if (root_bits_o !== want) report_mismatch("root_bits", root_bits_o, want);
        end
      end
      if (num_checked >= 30 && hold_off != 0) begin
        hold_off <= hold_off - 1;
        root_bits_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        root_bits_ready_i <= 1'b0;
      end else begin
        root_bits_ready_i <= 1'b1;
        if (root_bits_valid_o && root_bits_ready_i) recv_gap <= draw_gap();
      end
    end
  end

  // Watchdog on cycles without any transaction, and the end of the run.
  initial begin
    idle_cycles = 0;
    num_errors = 0;
    @(posedge rst_ni);
    while (!(stimulus_done && expected_roots.size() == 0)) begin
      @(posedge clk_i);
      if ((operand_bits_valid_i && operand_bits_ready_o) ||
          (root_bits_valid_o && root_bits_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: %0d results outstanding", expected_roots.size());
        $display("FAIL");
        $finish;
      end
    end
    repeat (60) @(posedge clk_i);
    if (root_bits_valid_o) report_mismatch("result after end", root_bits_o, 32'h0);
    $display("Checked %0d square roots: zeros, NaNs, infinities, negatives,", num_checked);
    $display("subnormals and random normals, with random stalls on both sides.");
    if (num_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/fsqrt_pkg.sv
rtl/fsqrt_recur.sv
rtl/float32_square_root.sv
tb/tb_float32_square_root.sv
